>>> sv/fit_policy_partition_allocator_assert.svh
// Assertion macros for the fit-policy partition allocator checker.
// Depends on signals named clk and arst_n in the module that uses them.
`ifndef FIT_POLICY_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_PARTITION_ALLOCATOR_ASSERT_SVH

// Implication in the same cycle.
`define FPA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/fpa_pkg.sv
// Shared types and constants of the fit-policy partition allocator.
// No dependencies; every other file but the assertion header imports it.
package fpa_pkg;

	localparam int BLK_W      = 4;
	localparam int AMT_W      = 16;
	localparam int SPACE_W    = 16;
	localparam int POLICY_W   = 2;
	localparam int ACT_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BLOCKS = 2'd1;

	localparam logic [ACT_W-1:0] ACTIVE_RESET = 5'd16;

	// Control part of the scan token that travels along the cell row.
	typedef struct packed {
		logic valid;
		logic found;
	} scan_ctl_t;

endpackage

>>> sv/fpa_if.sv
// Handshake channels of the fit-policy partition allocator.
// Depends on fpa_pkg for the field widths.
interface fpa_req_if import fpa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [BLK_W-1:0] block_index;
	logic [AMT_W-1:0] amount;

	modport source (output valid, req_type, block_index, amount, input ready);
	modport sink (input valid, req_type, block_index, amount, output ready);
endinterface

interface fpa_res_if import fpa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               granted;
	logic [BLK_W-1:0]   chosen_block;
	logic [SPACE_W-1:0] space_left;

	modport source (output valid, granted, chosen_block, space_left, input ready);
	modport sink (input valid, granted, chosen_block, space_left, output ready);
endinterface

interface fpa_cfg_if import fpa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

>>> sv/fit_policy_partition_allocator.sv
// Fit-policy partition allocator: a row of NUM_BLOCKS cells scanned by a
// travelling token. A load goes straight to the write-back; an allocate first
// passes the token along the row, one cell per cycle, then the write-back.
// One item at a time: a new item is accepted only once the last has finished
// its write-back. Reset clears every partition's free space, selects first
// fit and sets 16 active partitions.
module fit_policy_partition_allocator import fpa_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input logic      clk,
	input logic      arst_n,
	fpa_cfg_if.sink  cfg,
	fpa_req_if.sink  req,
	fpa_res_if.source res
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [POLICY_W-1:0] fit_policy_q;
	logic [ACT_W-1:0]    active_blocks_q;

	logic                kind_q;
	logic [BLK_W-1:0]    blk_q;
	logic [AMT_W-1:0]    amt_q;
	logic                found_q;
	logic [IDX_W-1:0]    pick_q;
	logic [SIZE_BITS-1:0] best_q;

	logic                res_valid_q;
	logic                res_granted_q;
	logic [BLK_W-1:0]    res_blk_q;
	logic [SPACE_W-1:0]  res_space_q;

	scan_ctl_t            ctl_w  [NUM_BLOCKS+1];
	logic [IDX_W-1:0]     pick_w [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0] best_w [NUM_BLOCKS+1];

	logic                 req_fire;
	logic                 out_free;
	logic                 finish;
	logic                 ok;
	logic [IDX_W-1:0]     wr_idx;
	logic [SIZE_BITS-1:0] wr_space;
	logic                 wr_en;
	logic [AMT_W-1:0]     scan_amt;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !res_valid_q || res.ready;
	assign finish    = (state_q == ST_DONE) && out_free;

	// The first cell compares in the accepting cycle, before amt_q holds the request.
	assign scan_amt = req_fire ? req.amount : amt_q;

	assign ctl_w[0].valid = req_fire && (req.req_type == REQ_ALLOC);
	assign ctl_w[0].found = 1'b0;
	assign pick_w[0]      = '0;
	assign best_w[0]      = '0;

	for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
		fpa_cell #(
			.NUM_BLOCKS(NUM_BLOCKS),
			.SIZE_BITS (SIZE_BITS),
			.INDEX     (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.fit_policy   (fit_policy_q),
			.active_blocks(active_blocks_q),
			.amount       (scan_amt),
			.wr_en        (wr_en),
			.wr_idx       (wr_idx),
			.wr_space     (wr_space),
			.ctl_in       (ctl_w[g]),
			.pick_in      (pick_w[g]),
			.best_in      (best_w[g]),
			.ctl_out      (ctl_w[g+1]),
			.pick_out     (pick_w[g+1]),
			.best_out     (best_w[g+1])
		);
	end

	// Write-back and result of the item that has finished its scan.
	always_comb begin
		if (kind_q == REQ_LOAD) begin
			ok       = 32'(blk_q) < NUM_BLOCKS;
			wr_idx   = IDX_W'(blk_q);
			wr_space = SIZE_BITS'(CMP_W'(amt_q));
		end else begin
			ok       = found_q;
			wr_idx   = pick_q;
			wr_space = SIZE_BITS'(CMP_W'(best_q) - CMP_W'(amt_q));
		end
	end

	assign wr_en = finish && ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q    <= POLICY_FIRST;
			active_blocks_q <= ACTIVE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.reg_index)
				CFG_FIT_POLICY:    fit_policy_q    <= cfg.wr_data[POLICY_W-1:0];
				CFG_ACTIVE_BLOCKS: active_blocks_q <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= (req.req_type == REQ_ALLOC) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (ctl_w[NUM_BLOCKS].valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q <= req.req_type;
			blk_q  <= req.block_index;
			amt_q  <= req.amount;
		end
		if ((state_q == ST_SCAN) && ctl_w[NUM_BLOCKS].valid) begin
			found_q <= ctl_w[NUM_BLOCKS].found;
			pick_q  <= pick_w[NUM_BLOCKS];
			best_q  <= best_w[NUM_BLOCKS];
		end
		if (finish) begin
			res_granted_q <= ok;
			res_blk_q     <= ok ? BLK_W'(wr_idx) : '0;
			res_space_q   <= ok ? SPACE_W'(wr_space) : '0;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.granted      = res_granted_q;
	assign res.chosen_block = res_blk_q;
	assign res.space_left   = res_space_q;

endmodule

>>> sv/fpa_cell.sv
// One cell of the partition row: holds one partition's free space and
// updates the scan token on its way to the next cell. Depends on fpa_pkg.
module fpa_cell import fpa_pkg::*; #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16,
	parameter int INDEX      = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [POLICY_W-1:0]  fit_policy,
	input  logic [ACT_W-1:0]     active_blocks,
	input  logic [AMT_W-1:0]     amount,
	input  logic                 wr_en,
	input  logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] wr_idx,
	input  logic [SIZE_BITS-1:0] wr_space,
	input  scan_ctl_t            ctl_in,
	input  logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] pick_in,
	input  logic [SIZE_BITS-1:0] best_in,
	output scan_ctl_t            ctl_out,
	output logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] pick_out,
	output logic [SIZE_BITS-1:0] best_out
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

	logic [SIZE_BITS-1:0] space_q;
	scan_ctl_t            ctl_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;

	logic in_range;
	logic fits;
	logic take;

	assign in_range = 32'(active_blocks) > INDEX;
	assign fits     = CMP_W'(space_q) >= CMP_W'(amount);

	always_comb begin
		take = 1'b0;
		if (ctl_in.valid && in_range && fits) begin
			if (!ctl_in.found) begin
				take = 1'b1;
			end else begin
				// Ties keep the earlier partition, so only strict compares replace.
				case (fit_policy)
					POLICY_BEST:  take = space_q < best_in;
					POLICY_WORST: take = space_q > best_in;
					default:      take = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_q <= '0;
			ctl_q   <= '0;
		end else begin
			if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
				space_q <= wr_space;
			end
			ctl_q.valid <= ctl_in.valid;
			ctl_q.found <= ctl_in.valid & (ctl_in.found | take);
		end
	end

	always_ff @(posedge clk) begin
		pick_q <= take ? IDX_W'(INDEX) : pick_in;
		best_q <= take ? space_q : best_in;
	end

	assign ctl_out  = ctl_q;
	assign pick_out = pick_q;
	assign best_out = best_q;

endmodule

>>> sv/fpa_checker.sv
// Port-level checks of the fit-policy partition allocator, bound to its top.
// Depends on fpa_pkg and the assertion macro header.
`include "fit_policy_partition_allocator_assert.svh"

module fpa_checker import fpa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic               res_granted,
	input logic [BLK_W-1:0]   res_chosen_block,
	input logic [SPACE_W-1:0] res_space_left
);

	// A refused transaction reports neither a partition nor any space.
	`FPA_ASSERT_SAME(a_refused_zero, res_valid && !res_granted, (res_chosen_block == '0) && (res_space_left == '0), "refused result carries nonzero fields")

	// Only one item is in flight, so the input closes right after a transaction.
	`FPA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "input ready while an item is in flight")

	`FPA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_granted) && $stable(res_chosen_block) && $stable(res_space_left), "stalled result changed or dropped")

endmodule

bind fit_policy_partition_allocator fpa_checker u_fpa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_granted     (res.granted),
	.res_chosen_block(res.chosen_block),
	.res_space_left  (res.space_left)
);

>>> verif/fit_policy_partition_allocator_test.sv
// Self-checking testbench for the fit-policy partition allocator.
// Depends on fpa_pkg and the channel interfaces in fpa_if; drives loads and allocations
// under changing fit policies and partition counts and checks every result in order.
module fit_policy_partition_allocator_test import fpa_pkg::*; ;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PARTITIONS = 16;
	localparam int MAX_GAP        = 12;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 2 * NUM_PARTITIONS + 4;
	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_ITEMS    = 50;

	// Register indexes that decode to nothing; writes there must leave the block alone.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam logic [POLICY_W-1:0]  POLICY_UNDEFINED = 2'd3;

	typedef struct packed {
		logic             req_type;
		logic [BLK_W-1:0] block_index;
		logic [AMT_W-1:0] amount;
	} alloc_req_t;

	typedef struct packed {
		logic               granted;
		logic [BLK_W-1:0]   chosen_block;
		logic [SPACE_W-1:0] space_left;
	} alloc_res_t;

	// Mirrors the partition table and the registers, and keeps the grants still owed.
	class partition_scoreboard;
		logic [SPACE_W-1:0]  free_space [NUM_PARTITIONS];
		logic [POLICY_W-1:0] policy;
		logic [ACT_W-1:0]    active;
		alloc_res_t          grants_owed [$];
		int errors;
		int loads;
		int allocs;
		int granted;
		int refused;

		function new();
			foreach (free_space[i])
				free_space[i] = '0;
			policy  = POLICY_FIRST;
			active  = ACTIVE_RESET;
			errors  = 0;
			loads   = 0;
			allocs  = 0;
			granted = 0;
			refused = 0;
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				CFG_FIT_POLICY:    policy = data[POLICY_W-1:0];
				CFG_ACTIVE_BLOCKS: active = data[ACT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(alloc_req_t r);
			alloc_res_t e;
			int span;
			int pick;
			bit found;
			e = '0;
			pick = 0;
			found = 1'b0;
			if (r.req_type == REQ_LOAD) begin
				loads++;
				free_space[r.block_index] = r.amount;
				e.granted = 1'b1;
				e.chosen_block = r.block_index;
				e.space_left = r.amount;
			end else begin
				allocs++;
				span = (active > NUM_PARTITIONS) ? NUM_PARTITIONS : int'(active);
				for (int j = 0; j < span; j++) begin
					if (free_space[j] >= r.amount) begin
						if (!found) begin
							found = 1'b1;
							pick = j;
							// First fit, and the undefined policy with it, stops at the first hit.
							if (policy != POLICY_BEST && policy != POLICY_WORST)
								break;
						end else if (policy == POLICY_BEST && free_space[j] < free_space[pick]) begin
							pick = j;
						end else if (policy == POLICY_WORST && free_space[j] > free_space[pick]) begin
							pick = j;
						end
					end
				end
				if (found) begin
					granted++;
					free_space[pick] = free_space[pick] - r.amount;
					e.granted = 1'b1;
					e.chosen_block = pick[BLK_W-1:0];
					e.space_left = free_space[pick];
				end else begin
					refused++;
				end
			end
			grants_owed.push_back(e);
		endfunction

		function void check_result(alloc_res_t got);
			alloc_res_t e;
			if (grants_owed.size() == 0) begin
				$error("unexpected result: granted %0d chosen_block %0d space_left %0d",
					got.granted, got.chosen_block, got.space_left);
				errors++;
				return;
			end
			e = grants_owed.pop_front();
			if (got.granted !== e.granted) begin
				$error("granted: expected %0d, actual %0d", e.granted, got.granted);
				errors++;
			end
			if (got.chosen_block !== e.chosen_block) begin
				$error("chosen_block: expected %0d, actual %0d", e.chosen_block, got.chosen_block);
				errors++;
			end
			if (got.space_left !== e.space_left) begin
				$error("space_left: expected %0d, actual %0d", e.space_left, got.space_left);
				errors++;
			end
		endfunction

		function int pending();
			return grants_owed.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fpa_cfg_if cfg_ch ();
	fpa_req_if req_ch ();
	fpa_res_if res_ch ();

	fit_policy_partition_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.res    (res_ch)
	);

	partition_scoreboard sb;
	bit no_gaps;
	bit hold_request;
	int reg_settings;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500us;
		$display("fit_policy_partition_allocator_test NOT OK");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off that backs the block up.
	initial begin
		int stall;
		alloc_res_t got;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			got.granted = res_ch.granted;
			got.chosen_block = res_ch.chosen_block;
			got.space_left = res_ch.space_left;
			sb.check_result(got);
		end
	end

	// Valid stays high from one transaction to the next when the drawn gap is zero.
	task automatic send_item(input logic kind, input logic [BLK_W-1:0] idx,
			input logic [AMT_W-1:0] amt);
		alloc_req_t r;
		int gap;
		r.req_type = kind;
		r.block_index = idx;
		r.amount = amt;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.req_type;
		req_ch.block_index <= r.block_index;
		req_ch.amount <= r.amount;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(r);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] policy_word,
			input logic [CFG_DATA_W-1:0] active_word, input bit touch_spare);
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [CFG_DATA_W-1:0] dat [4];
		int n;
		drain_results();
		idx[0] = CFG_FIT_POLICY;
		dat[0] = policy_word;
		idx[1] = CFG_ACTIVE_BLOCKS;
		dat[1] = active_word;
		idx[2] = CFG_SPARE_A;
		dat[2] = CFG_DATA_W'($urandom_range(0, 31));
		idx[3] = CFG_SPARE_B;
		dat[3] = CFG_DATA_W'($urandom_range(0, 31));
		n = touch_spare ? 4 : 2;
		for (int k = 0; k < n; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.reg_index <= idx[k];
			cfg_ch.wr_data <= dat[k];
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
			sb.configure(idx[k], dat[k]);
		end
		cfg_ch.valid <= 1'b0;
		reg_settings++;
	endtask

	// Most allocations are sized from the mirrored table so that grants stay frequent.
	task automatic send_random_items(input int count);
		logic kind;
		logic [BLK_W-1:0] idx;
		logic [AMT_W-1:0] amt;
		int j;
		for (int i = 0; i < count; i++) begin
			idx = BLK_W'($urandom_range(0, NUM_PARTITIONS - 1));
			j = $urandom_range(0, NUM_PARTITIONS - 1);
			if ($urandom_range(0, 9) < 3) begin
				kind = REQ_LOAD;
				case ($urandom_range(0, 7))
					0:       amt = '1;
					1:       amt = '0;
					2, 3:    amt = AMT_W'($urandom_range(0, 65535));
					default: amt = AMT_W'($urandom_range(1, 2000));
				endcase
			end else begin
				kind = REQ_ALLOC;
				case ($urandom_range(0, 7))
					0, 1, 2: amt = AMT_W'($urandom_range(0, sb.free_space[j]));
					3:       amt = sb.free_space[j];
					4:       amt = AMT_W'($urandom_range(0, 200));
					5:       amt = '0;
					6:       amt = AMT_W'($urandom_range(0, 65535));
					default: amt = sb.free_space[j] + 1'b1;
				endcase
			end
			send_item(kind, idx, amt);
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] policy_word;
		logic [CFG_DATA_W-1:0] active_word;
		sb = new();
		reg_settings = 0;
		no_gaps = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.block_index = '0;
		req_ch.amount = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = CFG_FIT_POLICY;
		cfg_ch.wr_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// A zero request fits the empty table; anything larger does not.
		program_regs(CFG_DATA_W'(POLICY_FIRST), CFG_DATA_W'(16), 1'b0);
		send_item(REQ_ALLOC, 4'd0, 16'd0);
		send_item(REQ_ALLOC, 4'd7, 16'd1);
		send_item(REQ_LOAD, 4'd0, 16'hFFFF);
		send_item(REQ_LOAD, 4'd15, 16'h8000);
		send_item(REQ_LOAD, 4'd5, 16'd100);
		send_item(REQ_LOAD, 4'd9, 16'd50);
		send_item(REQ_LOAD, 4'd12, 16'd100);
		send_item(REQ_LOAD, 4'd3, 16'h5555);
		send_item(REQ_ALLOC, 4'd0, 16'hFFFF);
		send_item(REQ_ALLOC, 4'd0, 16'd40);

		// Best fit, with a tie between partitions 5 and 12, then an exact fit.
		program_regs(CFG_DATA_W'(POLICY_BEST), CFG_DATA_W'(16), 1'b0);
		send_item(REQ_ALLOC, 4'd0, 16'd60);
		send_item(REQ_ALLOC, 4'd0, 16'd50);

		program_regs(CFG_DATA_W'(POLICY_WORST), CFG_DATA_W'(16), 1'b0);
		send_item(REQ_ALLOC, 4'd0, 16'h0010);
		send_item(REQ_ALLOC, 4'd0, 16'hAAAA);

		// Undefined policy acts as first fit; a count above the table saturates.
		program_regs({3'b111, POLICY_UNDEFINED}, CFG_DATA_W'(31), 1'b1);
		send_item(REQ_ALLOC, 4'd0, 16'd30);
		send_item(REQ_LOAD, 4'd14, 16'h2AAA);

		program_regs(CFG_DATA_W'(POLICY_WORST), CFG_DATA_W'(0), 1'b0);
		send_item(REQ_ALLOC, 4'd0, 16'd0);

		program_regs(CFG_DATA_W'(POLICY_BEST), CFG_DATA_W'(1), 1'b0);
		send_item(REQ_ALLOC, 4'd0, 16'd0);
		send_item(REQ_ALLOC, 4'd0, 16'd1);

		program_regs(CFG_DATA_W'(POLICY_FIRST), CFG_DATA_W'(17), 1'b0);
		send_item(REQ_ALLOC, 4'd0, 16'h7FF0);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			policy_word = {3'($urandom_range(0, 7)), 2'($urandom_range(0, 3))};
			case ($urandom_range(0, 9))
				0:       active_word = CFG_DATA_W'(0);
				1:       active_word = CFG_DATA_W'(1);
				2:       active_word = CFG_DATA_W'(16);
				3:       active_word = CFG_DATA_W'($urandom_range(17, 31));
				default: active_word = CFG_DATA_W'($urandom_range(2, 16));
			endcase
			program_regs(policy_word, active_word, $urandom_range(0, 3) == 0);
			no_gaps = (phase % 4 == 3);
			if (phase == 2)
				hold_request = 1'b1;
			send_random_items(PHASE_ITEMS);
		end
		no_gaps = 1'b0;
		drain_results();

		$display("Covered %0d loads and %0d allocations (%0d granted, %0d refused)",
			sb.loads, sb.allocs, sb.granted, sb.refused);
		$display("under %0d register settings, with a long result stall midway.", reg_settings);
		if (sb.errors == 0)
			$display("fit_policy_partition_allocator_test OK");
		else
			$display("fit_policy_partition_allocator_test NOT OK");
		$finish;
	end

endmodule
